### design/ufr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ufr_pkg;

  localparam logic [31:0] BASE_RESET = 32'h0810_8000;
  localparam logic [7:0]  START_BYTE = 8'hF0;
  localparam logic [7:0]  END_CMD    = 8'hF2;
  localparam logic [7:0]  ACK_BYTE   = 8'h21;
  localparam logic [7:0]  CRC_POLY   = 8'h31;

  localparam logic [2:0] KIND_START_ACK  = 3'd0;
  localparam logic [2:0] KIND_COMMIT_ACK = 3'd1;
  localparam logic [2:0] KIND_END_ACK    = 3'd2;
  localparam logic [2:0] KIND_STAGED     = 3'd3;
  localparam logic [2:0] KIND_CRC_DROP   = 3'd4;
  localparam logic [2:0] KIND_TMO_DROP   = 3'd5;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [31:0] out_address;
    logic [7:0]  out_data;
    logic [7:0]  out_length;
    logic [31:0] out_total;
  } rsp_t;

endpackage

`default_nettype wire

### design/update_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none

// Receiver for a CRC-8 framed firmware image stream.
// Input channel: in_valid/in_stall carry one request, a received byte or a
// receive timeout. Output channel: out_valid/out_stall carry acks, staged
// payload bytes with their flash address, and discard reports.
// cfg_we/cfg_wdata write the image base address; write only while idle.
// A request is held in an input register, parsed when the output register is
// free and its result lands in the output register: out_valid rises once the
// result is registered. One request per cycle is sustained while out_stall
// stays low; the frame state update of one request feeds the next directly.
// Requests that give no result still pass through the parser.
// While the receiver stalls, one more request is taken into the input
// register; then in_stall rises until the result is taken.
// Synchronous reset clears the pipeline, returns to waiting for the start
// byte, zeroes the write offset and sets the base address to 0x08108000.
module update_frame_receiver #(
  parameter logic [31:0] BASE_ADDR_RESET = ufr_pkg::BASE_RESET
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ufr_pkg::req_t in_req,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ufr_pkg::rsp_t      out_rsp,
  input  wire logic          cfg_we,
  input  wire logic [31:0]   cfg_wdata
);
  import ufr_pkg::*;

  logic        hold_valid;
  req_t        hold;
  logic [31:0] image_base_address;
  logic        adv;
  logic        accept;
  logic        res_valid;
  rsp_t        res;

  assign adv      = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !adv;
  assign accept   = in_valid && !in_stall;

  ufr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .go        (adv),
    .req       (hold),
    .base      (image_base_address),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      image_base_address <= BASE_ADDR_RESET;
    end else if (cfg_we) begin
      image_base_address <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (adv) begin
      hold_valid <= 1'b0;
    end
    if (accept) begin
      hold <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res_valid;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
    if (adv && res_valid) begin
      out_rsp <= res;
    end
  end

`ifndef SYNTHESIS
  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !adv |=> hold_valid && $stable(hold))
    else $error("held request lost");

  a_staged_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rsp.out_kind == KIND_STAGED |-> out_rsp.out_length != 8'd0)
    else $error("staged byte with zero length");

  a_commit_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rsp.out_kind == KIND_COMMIT_ACK |-> out_rsp.out_data == ACK_BYTE)
    else $error("commit without ack byte");
`endif

endmodule

`default_nettype wire

### design/ufr_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module ufr_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          go,
  input  wire ufr_pkg::req_t req,
  input  wire logic [31:0]   base,
  output logic               res_valid,
  output ufr_pkg::rsp_t      res
);
  import ufr_pkg::*;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_CMD     = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  phase_t      phase, phase_next;
  logic        frame_is_end, frame_is_end_next;
  logic [7:0]  payload_length, payload_length_next;
  logic [7:0]  bytes_seen, bytes_seen_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [31:0] write_offset, write_offset_next;
  logic [31:0] chunk_addr;
  logic [7:0]  seen_inc;

  assign chunk_addr = base + write_offset;
  assign seen_inc   = bytes_seen + 8'd1;

  always_comb begin
    phase_next          = phase;
    frame_is_end_next   = frame_is_end;
    payload_length_next = payload_length;
    bytes_seen_next     = bytes_seen;
    running_crc_next    = running_crc;
    write_offset_next   = write_offset;
    res_valid           = 1'b0;
    res.out_kind        = KIND_START_ACK;
    res.out_address     = chunk_addr;
    res.out_data        = 8'd0;
    res.out_length      = payload_length;
    if (req.req_type) begin
      if (phase == PH_LEN || phase == PH_PAYLOAD || phase == PH_CRC) begin
        res_valid           = 1'b1;
        res.out_kind        = KIND_TMO_DROP;
        res.out_length      = (phase == PH_LEN) ? 8'd0 : payload_length;
        phase_next          = PH_CMD;
        frame_is_end_next   = 1'b0;
        payload_length_next = 8'd0;
        bytes_seen_next     = 8'd0;
        running_crc_next    = 8'd0;
      end
    end else begin
      case (phase)
        PH_START: begin
          if (req.rx_byte == START_BYTE) begin
            res_valid           = 1'b1;
            res.out_kind        = KIND_START_ACK;
            res.out_address     = base;
            res.out_data        = ACK_BYTE;
            res.out_length      = 8'd0;
            write_offset_next   = 32'd0;
            phase_next          = PH_CMD;
            frame_is_end_next   = 1'b0;
            payload_length_next = 8'd0;
            bytes_seen_next     = 8'd0;
            running_crc_next    = 8'd0;
          end
        end
        PH_CMD: begin
          frame_is_end_next = (req.rx_byte == END_CMD);
          phase_next        = PH_LEN;
        end
        PH_LEN: begin
          payload_length_next = req.rx_byte;
          bytes_seen_next     = 8'd0;
          running_crc_next    = 8'd0;
          if (frame_is_end) begin
            res_valid      = 1'b1;
            res.out_kind   = KIND_END_ACK;
            res.out_data   = ACK_BYTE;
            res.out_length = req.rx_byte;
            phase_next     = PH_DONE;
          end else begin
            phase_next = (req.rx_byte == 8'd0) ? PH_CRC : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          res_valid        = 1'b1;
          res.out_kind     = KIND_STAGED;
          res.out_address  = chunk_addr + {24'd0, bytes_seen};
          res.out_data     = req.rx_byte;
          running_crc_next = crc_update(running_crc, req.rx_byte);
          bytes_seen_next  = seen_inc;
          if (seen_inc == payload_length) begin
            phase_next = PH_CRC;
          end
        end
        PH_CRC: begin
          res_valid = 1'b1;
          if (req.rx_byte == running_crc) begin
            res.out_kind      = KIND_COMMIT_ACK;
            res.out_data      = ACK_BYTE;
            write_offset_next = write_offset + {24'd0, payload_length};
          end else begin
            res.out_kind = KIND_CRC_DROP;
          end
          phase_next          = PH_CMD;
          frame_is_end_next   = 1'b0;
          payload_length_next = 8'd0;
          bytes_seen_next     = 8'd0;
          running_crc_next    = 8'd0;
        end
        default: begin
        end
      endcase
    end
    res.out_total = write_offset_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      frame_is_end   <= 1'b0;
      payload_length <= 8'd0;
      bytes_seen     <= 8'd0;
      running_crc    <= 8'd0;
      write_offset   <= 32'd0;
    end else if (go) begin
      phase          <= phase_next;
      frame_is_end   <= frame_is_end_next;
      payload_length <= payload_length_next;
      bytes_seen     <= bytes_seen_next;
      running_crc    <= running_crc_next;
      write_offset   <= write_offset_next;
    end
  end

`ifndef SYNTHESIS
  a_payload_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> bytes_seen < payload_length)
    else $error("payload index beyond length");

  a_offset_clear_before_start: assert property (@(posedge clk) disable iff (rst)
    phase == PH_START |-> write_offset == 32'd0)
    else $error("offset nonzero before start");

  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |=> phase == PH_DONE)
    else $error("left done phase");
`endif

endmodule

`default_nettype wire
